@@ rtl/cpu8_pkg.sv @@
// ----------------------------------------------------------------------------
// cpu8_pkg
// Shared types, opcode codes and constants for the 8-bit CPU execute unit.
// ----------------------------------------------------------------------------
package cpu8_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 48;

    // implemented opcodes
    localparam logic [7:0] OPC_SEI     = 8'h78;
    localparam logic [7:0] OPC_CLD     = 8'hD8;
    localparam logic [7:0] OPC_SED     = 8'hF8;
    localparam logic [7:0] OPC_CLC     = 8'h18;
    localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
    localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
    localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
    localparam logic [7:0] OPC_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OPC_LDA_ABS = 8'hAD;
    localparam logic [7:0] OPC_LDX_ZP  = 8'hA6;
    localparam logic [7:0] OPC_TXS     = 8'h9A;
    localparam logic [7:0] OPC_TXA     = 8'h8A;
    localparam logic [7:0] OPC_TAX     = 8'hAA;
    localparam logic [7:0] OPC_TAY     = 8'hA8;
    localparam logic [7:0] OPC_AND_IMM = 8'h29;
    localparam logic [7:0] OPC_AND_ZP  = 8'h25;
    localparam logic [7:0] OPC_ORA_IMM = 8'h09;
    localparam logic [7:0] OPC_ORA_ZP  = 8'h05;
    localparam logic [7:0] OPC_EOR_IMM = 8'h49;
    localparam logic [7:0] OPC_EOR_ZP  = 8'h45;
    localparam logic [7:0] OPC_ASL_A   = 8'h0A;
    localparam logic [7:0] OPC_LSR_A   = 8'h4A;
    localparam logic [7:0] OPC_ROR_A   = 8'h6A;
    localparam logic [7:0] OPC_CMP_IMM = 8'hC9;
    localparam logic [7:0] OPC_CPY_IMM = 8'hC0;
    localparam logic [7:0] OPC_CPY_ZP  = 8'hC4;

    // known, not carried out: one byte
    localparam logic [7:0] OPC_INX      = 8'hE8;
    localparam logic [7:0] OPC_INY      = 8'hC8;
    localparam logic [7:0] OPC_DEX      = 8'hCA;
    localparam logic [7:0] OPC_DEY      = 8'h88;
    localparam logic [7:0] OPC_PHA      = 8'h48;
    localparam logic [7:0] OPC_PLA      = 8'h68;
    localparam logic [7:0] OPC_RTS      = 8'h60;
    // two bytes
    localparam logic [7:0] OPC_STA_ZPX  = 8'h95;
    localparam logic [7:0] OPC_BNE      = 8'hD0;
    localparam logic [7:0] OPC_STX_ZP   = 8'h86;
    localparam logic [7:0] OPC_STY_ZPX  = 8'h94;
    localparam logic [7:0] OPC_BPL      = 8'h10;
    localparam logic [7:0] OPC_STY_ZP   = 8'h84;
    localparam logic [7:0] OPC_STA_ZP   = 8'h85;
    localparam logic [7:0] OPC_INC_ZP   = 8'hE6;
    localparam logic [7:0] OPC_DEC_ZP   = 8'hC6;
    localparam logic [7:0] OPC_ROL_ZP   = 8'h26;
    localparam logic [7:0] OPC_BEQ      = 8'hF0;
    localparam logic [7:0] OPC_ADC_IMM  = 8'h69;
    localparam logic [7:0] OPC_BCS      = 8'hB0;
    localparam logic [7:0] OPC_LDA_ZPX  = 8'hB5;
    localparam logic [7:0] OPC_EOR_ZPX  = 8'h55;
    localparam logic [7:0] OPC_ADC_ZP   = 8'h65;
    localparam logic [7:0] OPC_LDA_INDY = 8'hB1;
    localparam logic [7:0] OPC_ORA_INDY = 8'h11;
    localparam logic [7:0] OPC_BCC      = 8'h90;
    localparam logic [7:0] OPC_EOR_INDY = 8'h51;
    // three bytes
    localparam logic [7:0] OPC_LDA_ABSX = 8'hBD;
    localparam logic [7:0] OPC_JSR      = 8'h20;
    localparam logic [7:0] OPC_STX_ABS  = 8'h8E;
    localparam logic [7:0] OPC_AND_ABSY = 8'h39;
    localparam logic [7:0] OPC_EOR_ABSY = 8'h59;
    localparam logic [7:0] OPC_JMP      = 8'h4C;
    localparam logic [7:0] OPC_STA_ABSY = 8'h99;
    localparam logic [7:0] OPC_LDA_ABSY = 8'hB9;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_ONE  = 2'd1;
    localparam logic [1:0] LEN_TWO  = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef enum logic [4:0] {
        K_NOP,
        K_SEI,
        K_CLD,
        K_SED,
        K_CLC,
        K_LDX,
        K_LDY,
        K_LDA,
        K_TXS,
        K_TXA,
        K_TAX,
        K_TAY,
        K_AND,
        K_ORA,
        K_EOR,
        K_ASL,
        K_LSR,
        K_ROR,
        K_CMP,
        K_CPY
    } op_kind_t;

    // decoded instruction handed from the front end to the execute stage
    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  operand;
        logic [1:0]  len;
        logic        impl;
    } item_t;

endpackage

@@ rtl/cpu8_front.sv @@
// ----------------------------------------------------------------------------
// cpu8_front
// Input side: takes instruction beats, decodes opcode into an operation kind,
// picks the operand byte and works out length, then pushes into the queue.
// ----------------------------------------------------------------------------
module cpu8_front
(
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode[7:0], operand_low[15:8], operand_high[23:16], mem_data[31:24]
    input  logic [cpu8_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                            push,
    output cpu8_pkg::item_t                 push_item,
    input  logic                            queue_full
);
    import cpu8_pkg::*;

    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] mem_data;
    op_kind_t   kind;
    logic       use_mem;
    logic [1:0] len;

    assign opcode      = s_axis_tdata[7:0];
    assign operand_low = s_axis_tdata[15:8];
    // operand_high (bits 23:16) carries no effect: the byte already sits in mem_data
    assign mem_data    = s_axis_tdata[31:24];

    always_comb
    begin
        kind    = K_NOP;
        use_mem = 1'b0;
        len     = LEN_NONE;
        unique case (opcode)
            OPC_SEI:     begin kind = K_SEI; len = LEN_ONE; end
            OPC_CLD:     begin kind = K_CLD; len = LEN_ONE; end
            OPC_SED:     begin kind = K_SED; len = LEN_ONE; end
            OPC_CLC:     begin kind = K_CLC; len = LEN_ONE; end
            OPC_LDX_IMM: begin kind = K_LDX; len = LEN_TWO; end
            OPC_LDY_IMM: begin kind = K_LDY; len = LEN_TWO; end
            OPC_LDA_IMM: begin kind = K_LDA; len = LEN_TWO; end
            OPC_LDA_ZP:  begin kind = K_LDA; len = LEN_TWO; use_mem = 1'b1; end
            OPC_LDA_ABS: begin kind = K_LDA; len = LEN_THREE; use_mem = 1'b1; end
            OPC_LDX_ZP:  begin kind = K_LDX; len = LEN_TWO; use_mem = 1'b1; end
            OPC_TXS:     begin kind = K_TXS; len = LEN_ONE; end
            OPC_TXA:     begin kind = K_TXA; len = LEN_ONE; end
            OPC_TAX:     begin kind = K_TAX; len = LEN_ONE; end
            OPC_TAY:     begin kind = K_TAY; len = LEN_ONE; end
            OPC_AND_IMM: begin kind = K_AND; len = LEN_TWO; end
            OPC_AND_ZP:  begin kind = K_AND; len = LEN_TWO; use_mem = 1'b1; end
            OPC_ORA_IMM: begin kind = K_ORA; len = LEN_TWO; end
            OPC_ORA_ZP:  begin kind = K_ORA; len = LEN_TWO; use_mem = 1'b1; end
            OPC_EOR_IMM: begin kind = K_EOR; len = LEN_TWO; end
            OPC_EOR_ZP:  begin kind = K_EOR; len = LEN_TWO; use_mem = 1'b1; end
            OPC_ASL_A:   begin kind = K_ASL; len = LEN_ONE; end
            OPC_LSR_A:   begin kind = K_LSR; len = LEN_ONE; end
            OPC_ROR_A:   begin kind = K_ROR; len = LEN_ONE; end
            OPC_CMP_IMM: begin kind = K_CMP; len = LEN_TWO; end
            OPC_CPY_IMM: begin kind = K_CPY; len = LEN_TWO; end
            OPC_CPY_ZP:  begin kind = K_CPY; len = LEN_TWO; use_mem = 1'b1; end
            OPC_INX, OPC_INY, OPC_DEX, OPC_DEY, OPC_PHA, OPC_PLA, OPC_RTS:
                len = LEN_ONE;
            OPC_STA_ZPX, OPC_BNE, OPC_STX_ZP, OPC_STY_ZPX, OPC_BPL, OPC_STY_ZP,
            OPC_STA_ZP, OPC_INC_ZP, OPC_DEC_ZP, OPC_ROL_ZP, OPC_BEQ, OPC_ADC_IMM,
            OPC_BCS, OPC_LDA_ZPX, OPC_EOR_ZPX, OPC_ADC_ZP, OPC_LDA_INDY,
            OPC_ORA_INDY, OPC_BCC, OPC_EOR_INDY:
                len = LEN_TWO;
            OPC_LDA_ABSX, OPC_JSR, OPC_STX_ABS, OPC_AND_ABSY, OPC_EOR_ABSY,
            OPC_JMP, OPC_STA_ABSY, OPC_LDA_ABSY:
                len = LEN_THREE;
            default:
                len = LEN_NONE;
        endcase
    end

    assign s_axis_tready     = !queue_full;
    assign push              = s_axis_tvalid && !queue_full;
    assign push_item.kind    = kind;
    assign push_item.operand = use_mem ? mem_data : operand_low;
    assign push_item.len     = len;
    assign push_item.impl    = (kind != K_NOP);

endmodule

@@ rtl/cpu8_queue.sv @@
// ----------------------------------------------------------------------------
// cpu8_queue
// Short FIFO of decoded instructions between the front end and execute.
// ----------------------------------------------------------------------------
module cpu8_queue
#(
    parameter int DEPTH = cpu8_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpu8_pkg::item_t push_item,
    output logic            full,
    output logic            not_empty,
    output cpu8_pkg::item_t head_item,
    input  logic            pop
);
    import cpu8_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_item = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/cpu8_back.sv @@
// ----------------------------------------------------------------------------
// cpu8_back
// Execute stage: holds A, X, Y, SP and flags, carries out the queued
// instruction and presents the register snapshot in an output register.
// ----------------------------------------------------------------------------
module cpu8_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_not_empty,
    input  cpu8_pkg::item_t                  q_item,
    output logic                             q_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // acc_out[7:0], x_out[15:8], y_out[23:16], sp_out[31:24],
    // status_out[39:32], instr_length[41:40], implemented[42], zero pad
    output logic [cpu8_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cpu8_pkg::*;

    logic [7:0] acc_reg, acc_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] sp_reg, sp_next;
    logic       c_reg, c_next;
    logic       z_reg, z_next;
    logic       i_reg, i_next;
    logic       d_reg, d_next;
    logic       n_reg, n_next;
    logic       out_valid_reg;
    logic [1:0] len_reg;
    logic       impl_reg;

    logic [7:0] opnd;
    logic [7:0] cmp_src;
    logic [8:0] diff;
    logic [7:0] zn_val;
    logic       zn_en;

    assign opnd    = q_item.operand;
    assign cmp_src = (q_item.kind == K_CPY) ? y_reg : acc_reg;
    assign diff    = {1'b0, cmp_src} - {1'b0, opnd};

    // next architectural state for the instruction at the queue head
    always_comb
    begin
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        sp_next  = sp_reg;
        c_next   = c_reg;
        z_next   = z_reg;
        i_next   = i_reg;
        d_next   = d_reg;
        n_next   = n_reg;
        zn_val   = 8'h00;
        zn_en    = 1'b0;
        unique case (q_item.kind)
            K_NOP: ;
            K_SEI: i_next = 1'b1;
            K_CLD: d_next = 1'b0;
            K_SED: d_next = 1'b1;
            K_CLC: c_next = 1'b0;
            K_LDX: begin zn_val = opnd; x_next = zn_val; zn_en = 1'b1; end
            K_LDY: begin zn_val = opnd; y_next = zn_val; zn_en = 1'b1; end
            K_LDA: begin zn_val = opnd; acc_next = zn_val; zn_en = 1'b1; end
            K_TXS: sp_next = x_reg;
            K_TXA: begin zn_val = x_reg; acc_next = zn_val; zn_en = 1'b1; end
            K_TAX: begin zn_val = acc_reg; x_next = zn_val; zn_en = 1'b1; end
            K_TAY: begin zn_val = acc_reg; y_next = zn_val; zn_en = 1'b1; end
            K_AND: begin zn_val = acc_reg & opnd; acc_next = zn_val; zn_en = 1'b1; end
            K_ORA: begin zn_val = acc_reg | opnd; acc_next = zn_val; zn_en = 1'b1; end
            K_EOR: begin zn_val = acc_reg ^ opnd; acc_next = zn_val; zn_en = 1'b1; end
            K_ASL:
            begin
                c_next   = acc_reg[7];
                zn_val   = {acc_reg[6:0], 1'b0};
                acc_next = zn_val;
                zn_en    = 1'b1;
            end
            K_LSR:
            begin
                c_next   = acc_reg[0];
                zn_val   = {1'b0, acc_reg[7:1]};
                acc_next = zn_val;
                zn_en    = 1'b1;
            end
            K_ROR:
            begin
                c_next   = acc_reg[0];
                zn_val   = {c_reg, acc_reg[7:1]};
                acc_next = zn_val;
                zn_en    = 1'b1;
            end
            K_CMP, K_CPY:
            begin
                c_next = !diff[8];
                z_next = (cmp_src == opnd);
                n_next = diff[7];
            end
            default: ;
        endcase
        if (zn_en)
        begin
            z_next = (zn_val == 8'h00);
            n_next = zn_val[7];
        end
    end

    // output register frees as soon as its beat is taken
    assign q_pop = q_not_empty && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 8'h00;
            x_reg         <= 8'h00;
            y_reg         <= 8'h00;
            sp_reg        <= 8'h00;
            c_reg         <= 1'b0;
            z_reg         <= 1'b0;
            i_reg         <= 1'b0;
            d_reg         <= 1'b0;
            n_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                acc_reg <= acc_next;
                x_reg   <= x_next;
                y_reg   <= y_next;
                sp_reg  <= sp_next;
                c_reg   <= c_next;
                z_reg   <= z_next;
                i_reg   <= i_next;
                d_reg   <= d_next;
                n_reg   <= n_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            len_reg  <= q_item.len;
            impl_reg <= q_item.impl;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, impl_reg, len_reg,
                            n_reg, 3'b000, d_reg, i_reg, z_reg, c_reg,
                            sp_reg, y_reg, x_reg, acc_reg};

endmodule

@@ rtl/cpu8_subset_execute_unit.sv @@
// Path: an accepted input beat is stored in the queue, then its result is held in the
// output register, where it waits while the result side stalls.
// Throughput: one instruction per cycle while the result side does not stall, set by
// the single execute stage that updates the register file from the queue head.
// Reset: A, X, Y, SP and all flags clear to zero; queue empty, no result valid.
// ----------------------------------------------------------------------------
// cpu8_subset_execute_unit
// Execute unit for a subset of an 8-bit CPU instruction set: decode front end,
// instruction queue and execute stage with the architectural registers.
// ----------------------------------------------------------------------------
module cpu8_subset_execute_unit
#(
    parameter int QUEUE_DEPTH = cpu8_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // opcode[7:0], operand_low[15:8], operand_high[23:16], mem_data[31:24]
    input  logic [cpu8_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // acc_out[7:0], x_out[15:8], y_out[23:16], sp_out[31:24],
    // status_out[39:32], instr_length[41:40], implemented[42], zero pad
    output logic [cpu8_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cpu8_pkg::*;

    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  q_not_empty;
    item_t q_item;
    logic  q_pop;

    cpu8_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_item     (push_item),
        .queue_full    (queue_full)
    );

    cpu8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .not_empty (q_not_empty),
        .head_item (q_item),
        .pop       (q_pop)
    );

    cpu8_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/cpu8_checker.sv @@
// ----------------------------------------------------------------------------
// cpu8_checker
// Port-level checks on the execute unit's result stream.
// ----------------------------------------------------------------------------
module cpu8_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cpu8_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cpu8_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // status bits 4..6 never set
    a_status_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[38:36] == 3'b000)
        else $error("status reserved bits set");

    // unknown opcode never flagged as implemented
    a_len_impl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[41:40] == LEN_NONE |-> !m_axis_tdata[42])
        else $error("implemented with zero length");

    // no result beat valid straight after reset release
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_tdata_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:43] == 5'b00000)
        else $error("result pad bits set");

endmodule

bind cpu8_subset_execute_unit cpu8_checker u_cpu8_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
